### rtl/core/chd_pkg.sv
// Shared types and constants for the canonical Huffman decoder.
// No dependencies; imported by the interfaces, chd_out_reg and the decoder.
`default_nettype none

package chd_pkg;

  localparam int OP_W     = 2;
  localparam int IDX_W    = 9;
  localparam int LEN_IN_W = 16;
  localparam int BYTE_W   = 8;
  localparam int SYM_W    = 9;
  localparam int KIND_W   = 3;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_DATA  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_SYMBOL  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_END     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BADCODE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BADLEN  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BUILT   = 3'd4;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol;
    logic [KIND_W-1:0] kind;
    logic              last;
  } chd_res_t;

endpackage

`default_nettype wire

### rtl/core/chd_if.sv
// Valid/ready channel interfaces for the decoder input and result streams.
// Depends on chd_pkg for field widths.
`default_nettype none

interface chd_in_if;
  import chd_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [IDX_W-1:0]    symbol_index;
  logic [LEN_IN_W-1:0] code_length;
  logic [BYTE_W-1:0]   data_byte;

  modport source (output valid, op, symbol_index, code_length, data_byte, input ready);
  modport sink   (input valid, op, symbol_index, code_length, data_byte, output ready);
endinterface

interface chd_out_if;
  import chd_pkg::*;
  logic              valid;
  logic              ready;
  logic [SYM_W-1:0]  symbol;
  logic [KIND_W-1:0] kind;
  logic              last;

  modport source (output valid, symbol, kind, last, input ready);
  modport sink   (input valid, symbol, kind, last, output ready);
endinterface

`default_nettype wire

### rtl/core/chd_alu.sv
// Shared add/subtract unit of the decoder sequencer.
// Carry out on subtract means a >= b. No package dependencies.
`default_nettype none

module chd_alu #(
  parameter int W = 34
) (
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  input  wire logic         sub_i,
  output logic [W-1:0]      sum_o,
  output logic              carry_o
);

  logic [W:0] full;

  always_comb begin
    full    = {1'b0, a_i} + {1'b0, (sub_i ? ~b_i : b_i)} + {{W{1'b0}}, sub_i};
    sum_o   = full[W-1:0];
    carry_o = full[W];
  end

endmodule

`default_nettype wire

### rtl/core/chd_out_reg.sv
// One-entry result register between the sequencer and the result channel.
// Depends on chd_pkg (chd_res_t) and chd_out_if.
`default_nettype none

module chd_out_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  input  wire chd_pkg::chd_res_t push_res_i,
  output logic                   push_ready_o,
  chd_out_if.source              out_o
);
  import chd_pkg::*;

  logic     valid_q;
  chd_res_t res_q;

  assign push_ready_o = !valid_q || out_o.ready;
  assign out_o.valid  = valid_q;
  assign out_o.symbol = res_q.symbol;
  assign out_o.kind   = res_q.kind;
  assign out_o.last   = res_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_ready_o) begin
      valid_q <= push_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i && push_ready_o) begin
      res_q <= push_res_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/canonical_huffman_decoder.sv
// Canonical Huffman decoder, sequencer and table memories around one shared adder.
// Load, build and data beats each run as a sequence of states over the shared adder;
// a stalled result channel holds the sequencer until the result can be passed on.
// One beat in flight at a time; ready only while the sequencer is idle.
// Reset (async, active low) starts a clearing pass over the length and count tables;
// a load after decoding or failure runs the same pass before it proceeds.
`default_nettype none

module canonical_huffman_decoder #(
  parameter int ALPHABET     = 257,
  parameter int MAX_CODE_LEN = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  chd_in_if.sink    in_i,
  chd_out_if.source out_o
);
  import chd_pkg::*;

  localparam int SW   = $clog2(ALPHABET);
  localparam int LN   = MAX_CODE_LEN + 1;
  localparam int LW   = $clog2(LN);
  localparam int PBW  = $clog2(MAX_CODE_LEN + 2);
  localparam int CW   = $clog2(ALPHABET + 1);
  localparam int FW   = MAX_CODE_LEN + 1;
  localparam int AW   = MAX_CODE_LEN + 2;
  localparam int CLRN = (ALPHABET > LN) ? ALPHABET : LN;
  localparam int CTW  = $clog2(CLRN);

  typedef enum logic [1:0] {PH_LOADING, PH_DECODING, PH_ENDED, PH_FAILED} phase_e;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_FIN,
    S_LD_CHK, S_LD_OLD, S_LD_DEC, S_LD_NEW, S_LD_INC,
    S_B_INIT, S_B_OFF, S_B_FST, S_B_F0, S_S_RD, S_S_LEN, S_S_WR, S_B_DONE,
    S_D_BIT, S_D_GE, S_D_LT, S_D_IDX, S_D_SYM, S_D_NXT
  } state_e;

  // memories
  logic [LW-1:0] lens_mem  [ALPHABET];
  logic [CW-1:0] cnt_mem   [LN];
  logic [FW-1:0] first_mem [LN];
  logic [CW-1:0] base_mem  [LN];
  logic [CW-1:0] next_mem  [LN];
  logic [SW-1:0] sort_mem  [ALPHABET];

  logic          lens_we, lens_re, cnt_we, cnt_re, first_we, first_re;
  logic          base_we, base_re, next_we, next_re, sort_we, sort_re;
  logic [SW-1:0] lens_wa, lens_ra, sort_wa, sort_ra;
  logic [LW-1:0] cnt_wa, cnt_ra, first_wa, first_ra, bn_wa, base_ra, next_ra;
  logic [LW-1:0] lens_wd;
  logic [CW-1:0] cnt_wd, base_wd, next_wd;
  logic [FW-1:0] first_wd;
  logic [SW-1:0] sort_wd;
  logic [LW-1:0] lens_rd;
  logic [CW-1:0] cnt_rd, base_rd, next_rd;
  logic [FW-1:0] first_rd;
  logic [SW-1:0] sort_rd;

  always_ff @(posedge clk_i) begin
    if (lens_we)  lens_mem[lens_wa]   <= lens_wd;
    if (cnt_we)   cnt_mem[cnt_wa]     <= cnt_wd;
    if (first_we) first_mem[first_wa] <= first_wd;
    if (base_we)  base_mem[bn_wa]     <= base_wd;
    if (next_we)  next_mem[bn_wa]     <= next_wd;
    if (sort_we)  sort_mem[sort_wa]   <= sort_wd;
    if (lens_re)  lens_rd  <= lens_mem[lens_ra];
    if (cnt_re)   cnt_rd   <= cnt_mem[cnt_ra];
    if (first_re) first_rd <= first_mem[first_ra];
    if (base_re)  base_rd  <= base_mem[base_ra];
    if (next_re)  next_rd  <= next_mem[next_ra];
    if (sort_re)  sort_rd  <= sort_mem[sort_ra];
  end

  // sequencer registers
  state_e                state_q, state_d;
  phase_e                phase_q, phase_d;
  logic [CTW-1:0]        ctr_q, ctr_d;
  logic                  pend_q, pend_d;
  logic [LW-1:0]         longest_q, longest_d;
  logic [MAX_CODE_LEN-1:0] pc_q, pc_d;
  logic [PBW-1:0]        pb_q, pb_d;
  logic [2:0]            bit_q, bit_d;
  logic [LW-1:0]         lcur_q, lcur_d;
  logic [LW-1:0]         lenx_q, lenx_d;
  logic [CW-1:0]         o_q, o_d;
  logic [FW-1:0]         f_q, f_d;
  logic [AW-1:0]         tmp_q, tmp_d;
  logic                  hold_v_q, hold_v_d;
  chd_res_t              hold_q, hold_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [LEN_IN_W-1:0]   len_q, len_d;
  logic [BYTE_W-1:0]     byte_q, byte_d;

  // shared adder
  logic [AW-1:0] alu_a, alu_b, alu_sum;
  logic          alu_sub, alu_carry;

  chd_alu #(.W(AW)) u_alu (
    .a_i(alu_a), .b_i(alu_b), .sub_i(alu_sub), .sum_o(alu_sum), .carry_o(alu_carry)
  );

  logic     push_valid, push_ready;
  chd_res_t push_res;

  chd_out_reg u_out (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_valid_i(push_valid), .push_res_i(push_res),
    .push_ready_o(push_ready), .out_o(out_o)
  );

  logic                    prod_req;
  logic [KIND_W-1:0]       prod_kind;
  logic [SYM_W-1:0]        prod_sym;
  logic                    fin_push;
  logic                    can_prod;
  logic [MAX_CODE_LEN-1:0] npc;
  logic [PBW-1:0]          npb;
  logic [SW-1:0]           idx_t;
  logic [LW-1:0]           len_t;
  logic [FW-1:0]           fn;

  assign in_i.ready = (state_q == S_IDLE);
  assign can_prod   = !hold_v_q || push_ready;
  assign idx_t      = SW'(idx_q);
  assign len_t      = LW'(len_q);
  assign npc        = {pc_q[MAX_CODE_LEN-2:0], byte_q[bit_q]};
  assign npb        = pb_q + PBW'(1);
  assign fn         = FW'(alu_sum >> 1);

  always_comb begin
    state_d = state_q;  phase_d = phase_q;  ctr_d = ctr_q;  pend_d = pend_q;
    longest_d = longest_q;  pc_d = pc_q;  pb_d = pb_q;  bit_d = bit_q;
    lcur_d = lcur_q;  lenx_d = lenx_q;  o_d = o_q;  f_d = f_q;  tmp_d = tmp_q;
    idx_d = idx_q;  len_d = len_q;  byte_d = byte_q;
    lens_we = 1'b0; lens_re = 1'b0; cnt_we = 1'b0; cnt_re = 1'b0;
    first_we = 1'b0; first_re = 1'b0; base_we = 1'b0; base_re = 1'b0;
    next_we = 1'b0; next_re = 1'b0; sort_we = 1'b0; sort_re = 1'b0;
    lens_wa = idx_t; lens_ra = idx_t; lens_wd = len_t;
    cnt_wa = lenx_q; cnt_ra = len_t; cnt_wd = '0;
    first_wa = lcur_q; first_ra = LW'(npb); first_wd = '0;
    bn_wa = lcur_q; base_ra = LW'(npb); next_ra = lens_rd;
    base_wd = o_q; next_wd = o_q;
    sort_wa = SW'(next_rd); sort_ra = SW'(alu_sum); sort_wd = SW'(ctr_q);
    alu_a = '0; alu_b = '0; alu_sub = 1'b0;
    prod_req = 1'b0; prod_kind = KIND_SYMBOL; prod_sym = '0;
    fin_push = 1'b0;

    unique case (state_q)
      S_CLR: begin
        lens_wa = SW'(ctr_q);
        cnt_wa  = LW'(ctr_q);
        lens_wd = '0;
        cnt_wd  = '0;
        lens_we = (32'(ctr_q) < ALPHABET);
        cnt_we  = (32'(ctr_q) < LN);
        if (ctr_q == CTW'(CLRN - 1)) begin
          pend_d  = 1'b0;
          state_d = pend_q ? S_LD_CHK : S_IDLE;
        end else begin
          ctr_d = ctr_q + CTW'(1);
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          idx_d  = in_i.symbol_index;
          len_d  = in_i.code_length;
          byte_d = in_i.data_byte;
          bit_d  = 3'd7;
          unique case (in_i.op)
            OP_LOAD: begin
              if (phase_q != PH_LOADING) begin
                // fresh codebook: wipe lengths and counts first
                phase_d = PH_LOADING; pc_d = '0; pb_d = '0; longest_d = '0;
                ctr_d = '0; pend_d = 1'b1; state_d = S_CLR;
              end else begin
                state_d = S_LD_CHK;
              end
            end
            OP_BUILD: state_d = (phase_q == PH_FAILED) ? S_IDLE : S_B_INIT;
            OP_DATA:  state_d = (phase_q == PH_DECODING) ? S_D_BIT : S_IDLE;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_FIN: begin
        if (!hold_v_q) state_d = S_IDLE;
        else if (push_ready) begin
          fin_push = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_LD_CHK: begin
        if (32'(idx_q) >= ALPHABET) begin
          state_d = S_IDLE;
        end else if (32'(len_q) > MAX_CODE_LEN) begin
          prod_req = 1'b1; prod_kind = KIND_BADLEN;
          phase_d = PH_FAILED; state_d = S_FIN;
        end else begin
          lens_re = 1'b1; state_d = S_LD_OLD;
        end
      end
      S_LD_OLD: begin
        lenx_d  = lens_rd;
        lens_we = 1'b1;
        if (len_t > longest_q) longest_d = len_t;
        cnt_ra  = lens_rd;
        if (lens_rd != '0) begin
          cnt_re = 1'b1; state_d = S_LD_DEC;
        end else begin
          state_d = S_LD_NEW;
        end
      end
      S_LD_DEC: begin
        alu_a = AW'(cnt_rd); alu_b = AW'(1); alu_sub = 1'b1;
        cnt_we = 1'b1; cnt_wd = CW'(alu_sum);
        state_d = S_LD_NEW;
      end
      S_LD_NEW: begin
        if (len_t != '0) begin
          cnt_re = 1'b1; state_d = S_LD_INC;
        end else begin
          state_d = S_FIN;
        end
      end
      S_LD_INC: begin
        alu_a = AW'(cnt_rd); alu_b = AW'(1);
        cnt_wa = len_t; cnt_we = 1'b1; cnt_wd = CW'(alu_sum);
        state_d = S_FIN;
      end
      S_B_INIT: begin
        first_wa = longest_q; first_we = 1'b1; first_wd = '0;
        lcur_d = longest_q; o_d = '0; f_d = '0;
        cnt_ra = longest_q;
        if (longest_q == '0) state_d = S_B_F0;
        else begin
          cnt_re = 1'b1; state_d = S_B_OFF;
        end
      end
      S_B_OFF: begin
        // symbol table is ordered by descending length, then by index
        tmp_d = AW'(cnt_rd);
        alu_a = AW'(o_q); alu_b = AW'(cnt_rd);
        base_we = 1'b1; next_we = 1'b1;
        o_d = CW'(alu_sum);
        state_d = (lcur_q >= LW'(2)) ? S_B_FST : S_B_F0;
      end
      S_B_FST: begin
        alu_a = AW'(f_q); alu_b = tmp_q;
        first_wa = lcur_q - LW'(1); first_we = 1'b1; first_wd = fn;
        f_d = fn;
        lcur_d = lcur_q - LW'(1);
        cnt_ra = lcur_q - LW'(1); cnt_re = 1'b1;
        state_d = S_B_OFF;
      end
      S_B_F0: begin
        first_wa = '0; first_we = 1'b1; first_wd = FW'(1);
        ctr_d = '0; state_d = S_S_RD;
      end
      S_S_RD: begin
        lens_ra = SW'(ctr_q); lens_re = 1'b1; state_d = S_S_LEN;
      end
      S_S_LEN: begin
        if (lens_rd != '0) begin
          lenx_d = lens_rd; next_re = 1'b1; state_d = S_S_WR;
        end else if (ctr_q == CTW'(ALPHABET - 1)) begin
          state_d = S_B_DONE;
        end else begin
          ctr_d = ctr_q + CTW'(1); state_d = S_S_RD;
        end
      end
      S_S_WR: begin
        alu_a = AW'(next_rd); alu_b = AW'(1);
        bn_wa = lenx_q; next_we = 1'b1; next_wd = CW'(alu_sum);
        sort_we = 1'b1;
        if (ctr_q == CTW'(ALPHABET - 1)) state_d = S_B_DONE;
        else begin
          ctr_d = ctr_q + CTW'(1); state_d = S_S_RD;
        end
      end
      S_B_DONE: begin
        prod_req = 1'b1; prod_kind = KIND_BUILT;
        phase_d = PH_DECODING; pc_d = '0; pb_d = '0;
        state_d = S_FIN;
      end
      S_D_BIT: begin
        if (npb > PBW'(longest_q)) begin
          if (can_prod) begin
            prod_req = 1'b1; prod_kind = KIND_BADCODE;
            phase_d = PH_FAILED; state_d = S_FIN;
          end
        end else begin
          pc_d = npc; pb_d = npb;
          first_re = 1'b1; base_re = 1'b1; cnt_re = 1'b1; cnt_ra = LW'(npb);
          state_d = S_D_GE;
        end
      end
      S_D_GE: begin
        alu_a = AW'(pc_q); alu_b = AW'(first_rd); alu_sub = 1'b1;
        if (alu_carry) begin
          tmp_d = alu_sum; state_d = S_D_LT;
        end else begin
          state_d = S_D_NXT;
        end
      end
      S_D_LT: begin
        // rank within this length must be below the symbol count
        alu_a = tmp_q; alu_b = AW'(cnt_rd); alu_sub = 1'b1;
        if (alu_carry) begin
          if (can_prod) begin
            prod_req = 1'b1; prod_kind = KIND_BADCODE;
            phase_d = PH_FAILED; pc_d = '0; pb_d = '0; state_d = S_FIN;
          end
        end else begin
          state_d = S_D_IDX;
        end
      end
      S_D_IDX: begin
        alu_a = AW'(base_rd); alu_b = tmp_q;
        sort_re = 1'b1; state_d = S_D_SYM;
      end
      S_D_SYM: begin
        if (can_prod) begin
          prod_req = 1'b1; prod_sym = SYM_W'(sort_rd);
          pc_d = '0; pb_d = '0;
          if (sort_rd == SW'(ALPHABET - 1)) begin
            prod_kind = KIND_END; phase_d = PH_ENDED; state_d = S_FIN;
          end else begin
            prod_kind = KIND_SYMBOL; state_d = S_D_NXT;
          end
        end
      end
      S_D_NXT: begin
        if (bit_q == 3'd0) state_d = S_FIN;
        else begin
          bit_d = bit_q - 3'd1; state_d = S_D_BIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // newest result is held back until it is known whether it ends the beat
  always_comb begin
    hold_v_d   = hold_v_q;
    hold_d     = hold_q;
    push_valid = 1'b0;
    push_res   = hold_q;
    if (prod_req) begin
      push_valid      = hold_v_q;
      push_res.last   = 1'b0;
      hold_v_d        = 1'b1;
      hold_d.symbol   = prod_sym;
      hold_d.kind     = prod_kind;
      hold_d.last     = 1'b1;
    end else if (fin_push) begin
      push_valid    = 1'b1;
      push_res.last = 1'b1;
      hold_v_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      phase_q   <= PH_LOADING;
      ctr_q     <= '0;
      pend_q    <= 1'b0;
      longest_q <= '0;
      pc_q      <= '0;
      pb_q      <= '0;
      bit_q     <= '0;
      hold_v_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      ctr_q     <= ctr_d;
      pend_q    <= pend_d;
      longest_q <= longest_d;
      pc_q      <= pc_d;
      pb_q      <= pb_d;
      bit_q     <= bit_d;
      hold_v_q  <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lcur_q <= lcur_d;
    lenx_q <= lenx_d;
    o_q    <= o_d;
    f_q    <= f_d;
    tmp_q  <= tmp_d;
    hold_q <= hold_d;
    idx_q  <= idx_d;
    len_q  <= len_d;
    byte_q <= byte_d;
  end

  a_bit_in_decoding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_D_BIT) |-> (phase_q == PH_DECODING))
    else $error("bit step outside decoding phase");

  a_partial_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_D_BIT) |-> (32'(pb_q) <= 32'(longest_q)))
    else $error("partial code longer than longest length");

  a_decode_after_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(phase_q == PH_DECODING) |-> ($past(state_q) == S_B_DONE))
    else $error("decoding entered without a table build");

  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !hold_v_q)
    else $error("held result left behind at idle");

endmodule

`default_nettype wire

### tb/sv/tb_canonical_huffman_decoder.sv
// Self-checking bench for canonical_huffman_decoder: directed codebooks, then random ones.
// Depends on chd_pkg, chd_if and the decoder RTL; carries its own decoder predictor.
`default_nettype none

module tb_canonical_huffman_decoder;
  import chd_pkg::*;

  localparam int NSYM   = 257;
  localparam int MAXLEN = 32;
  localparam int WDOG   = 20000;

  typedef enum logic [1:0] {ST_LOADING, ST_DECODING, ST_ENDED, ST_FAILED} dec_state_e;

  class huff_scoreboard;
    chd_res_t   pending[$];
    int unsigned errors;
    logic [5:0]  sym_len[NSYM];
    logic [8:0]  len_cnt[MAXLEN+1];
    logic [32:0] first_code[MAXLEN+1];
    logic [31:0] sym_code[NSYM];
    logic [5:0]  longest;
    logic [31:0] acc_code;
    logic [5:0]  acc_bits;
    dec_state_e  state;

    function void clear_book();
      foreach (sym_len[i]) sym_len[i] = '0;
      foreach (len_cnt[i]) len_cnt[i] = '0;
      longest = '0;
      acc_code = '0;
      acc_bits = '0;
      state = ST_LOADING;
    endfunction

    function new();
      errors = 0;
      clear_book();
      foreach (first_code[i]) first_code[i] = '0;
      foreach (sym_code[i]) sym_code[i] = '0;
    endfunction

    function void push(logic [8:0] s, logic [2:0] k);
      chd_res_t r;
      r.symbol = s;
      r.kind = k;
      r.last = 1'b0;
      pending.push_back(r);
    endfunction

    function void build_codes();
      logic [32:0] nxt[MAXLEN+1];
      foreach (nxt[i]) nxt[i] = '0;
      first_code[longest] = '0;
      for (int l = longest; l > 1; l--) begin
        first_code[l-1] = (first_code[l] + len_cnt[l]) >> 1;
        nxt[l-1] = first_code[l-1];
      end
      first_code[0] = 1;
      for (int i = 0; i < NSYM; i++) begin
        if (sym_len[i] != 0) begin
          sym_code[i] = nxt[sym_len[i]][31:0];
          nxt[sym_len[i]]++;
        end
      end
    endfunction

    // note one accepted input beat; queues the results it must cause
    function void note_input(logic [1:0] op, logic [8:0] idx, logic [15:0] len,
                             logic [7:0] data);
      int n;
      int hit;
      n = 0;
      if (op == OP_LOAD) begin
        if (state != ST_LOADING) clear_book();
        if (idx >= NSYM) return;
        if (len > MAXLEN) begin
          state = ST_FAILED;
          push('0, KIND_BADLEN);
          n = 1;
        end else begin
          if (sym_len[idx] != 0) len_cnt[sym_len[idx]]--;
          sym_len[idx] = len[5:0];
          if (len != 0) begin
            len_cnt[len]++;
            if (len > longest) longest = len[5:0];
          end
        end
      end else if (op == OP_BUILD) begin
        if (state == ST_FAILED) return;
        build_codes();
        acc_code = '0;
        acc_bits = '0;
        state = ST_DECODING;
        push('0, KIND_BUILT);
        n = 1;
      end else if (op == OP_DATA && state == ST_DECODING) begin
        for (int b = 7; b >= 0 && state == ST_DECODING; b--) begin
          acc_code = {acc_code[30:0], data[b]};
          acc_bits++;
          if (acc_bits > longest) begin
            push('0, KIND_BADCODE);
            n++;
            state = ST_FAILED;
          end else if ({1'b0, acc_code} >= first_code[acc_bits]) begin
            hit = -1;
            for (int i = 0; i < NSYM && hit < 0; i++)
              if (sym_len[i] == acc_bits && sym_code[i] == acc_code) hit = i;
            if (hit < 0) begin
              push('0, KIND_BADCODE);
              state = ST_FAILED;
            end else if (hit == NSYM - 1) begin
              push(hit[8:0], KIND_END);
              state = ST_ENDED;
            end else begin
              push(hit[8:0], KIND_SYMBOL);
            end
            n++;
            acc_code = '0;
            acc_bits = '0;
          end
        end
      end
      if (n > 0) pending[pending.size()-1].last = 1'b1;
    endfunction

    function void check_result(chd_res_t got);
      chd_res_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result sym=%0d kind=%0d last=%0d",
                                   got.symbol, got.kind, got.last);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp sym=%0d kind=%0d last=%0d, got sym=%0d kind=%0d last=%0d",
                   exp_r.symbol, exp_r.kind, exp_r.last, got.symbol, got.kind, got.last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  chd_in_if  in_ch();
  chd_out_if out_ch();

  canonical_huffman_decoder dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  huff_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  always @(posedge clk_i) begin
    out_ch.ready <= rst_ni ? ($urandom_range(99) >= recv_stall_pct) : 1'b0;
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result('{symbol: out_ch.symbol, kind: out_ch.kind, last: out_ch.last});
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // valid stays up after the accepting edge; the next beat or an idle gap replaces it
  task automatic send_beat(logic [1:0] op, logic [8:0] idx, logic [15:0] len,
                           logic [7:0] data);
    bit acc;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.symbol_index <= idx;
    in_ch.code_length <= len;
    in_ch.data_byte <= data;
    acc = 1'b0;
    while (!acc) begin
      @(negedge clk_i);
      acc = in_ch.ready;
      @(posedge clk_i);
    end
    sb.note_input(op, idx, len, data);
  endtask

  task automatic set_phase(int s, int r);
    send_idle_pct = s;
    recv_stall_pct = r;
  endtask

  // loads a random codebook: random indices and small lengths up to maxl, plus the end symbol if asked
  task automatic load_book(int nsym, int maxl, bit with_end);
    for (int i = 0; i < nsym; i++)
      send_beat(OP_LOAD, 9'($urandom_range(NSYM - 2)), 16'($urandom_range(maxl, 1)),
                8'($urandom));
    if (with_end) send_beat(OP_LOAD, 9'(NSYM - 1), 16'($urandom_range(maxl, 1)), '0);
  endtask

  initial begin
    int left;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.symbol_index = '0;
    in_ch.code_length = '0;
    in_ch.data_byte = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty codebook, small full tree, extremes and ignored items
    send_beat(OP_BUILD, '0, '0, '0);
    send_beat(OP_DATA, '0, '0, 8'h00);
    send_beat(OP_BUILD, '0, '0, '0);           // build in failed is dropped
    send_beat(OP_LOAD, 9'd0, 16'd1, '0);
    send_beat(OP_LOAD, 9'd1, 16'd2, '0);
    send_beat(OP_LOAD, 9'd2, 16'd3, '0);
    send_beat(OP_LOAD, 9'd256, 16'd3, '0);
    send_beat(OP_LOAD, 9'd511, 16'd5, '0);     // index out of range
    send_beat(2'd3, '0, '0, 8'hff);            // unused op
    send_beat(OP_DATA, '0, '0, 8'h55);         // ignored while loading
    send_beat(OP_BUILD, '0, '0, '0);
    send_beat(OP_DATA, '0, '0, 8'h4f);
    send_beat(OP_DATA, '0, '0, 8'hb3);
    send_beat(OP_BUILD, '0, '0, '0);           // rebuild after decoding
    send_beat(OP_DATA, '0, '0, 8'hff);
    send_beat(OP_LOAD, 9'd3, 16'd32, '0);      // restarts the codebook
    send_beat(OP_LOAD, 9'd3, 16'd0, '0);       // reload to absent
    send_beat(OP_LOAD, 9'd4, 16'd1, '0);
    send_beat(OP_LOAD, 9'd5, 16'd33, '0);
    send_beat(OP_LOAD, 9'd6, 16'hffff, '0);
    send_beat(OP_LOAD, 9'd7, 16'd32, '0);
    send_beat(OP_BUILD, '0, '0, '0);
    send_beat(OP_DATA, '0, '0, 8'h00);

    left = 155;
    for (int ph = 0; left > 0; ph++) begin
      case (ph % 4)
        0: set_phase(0, 0);
        1: set_phase(86, 0);
        2: set_phase(0, 86);
        default: set_phase(19, 19);
      endcase
      for (int g = 0; g < 3 && left > 0; g++) begin
        int nsym;
        nsym = $urandom_range(6, 2);
        load_book(nsym, ($urandom_range(9) == 0) ? MAXLEN : 4, $urandom_range(3) != 0);
        if ($urandom_range(9) == 0) send_beat(OP_LOAD, 9'($urandom), 16'($urandom), '0);
        send_beat(OP_BUILD, '0, '0, '0);
        for (int d = 0; d < 6; d++) send_beat(OP_DATA, '0, '0, 8'($urandom));
        if ($urandom_range(4) == 0)
          send_beat(2'($urandom), 9'($urandom), 16'($urandom), 8'($urandom));
        left -= nsym + 8;
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

`default_nettype wire

### sim.f
rtl/core/chd_pkg.sv
rtl/core/chd_if.sv
rtl/core/chd_alu.sv
rtl/core/chd_out_reg.sv
rtl/core/canonical_huffman_decoder.sv
tb/sv/tb_canonical_huffman_decoder.sv
